@@ hdl/selective_repeat_receive_window_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the selective-repeat receive window
// Define NO_ASSERTIONS to compile every check away.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SRRW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("srrw: same-cycle check failed");

// Next-cycle implication.
`define SRRW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("srrw: next-cycle check failed");

`else

`define SRRW_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SRRW_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/srrw_pkg.sv @@
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types, constants and helpers of the selective-repeat receive window.
// ----------------------------------------------------------------------------
`default_nettype none

package srrw_pkg;

  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned SEQ_BITS_W = 5;
  localparam int unsigned WIN_W      = 7;
  localparam int unsigned MAP_DEPTH  = 64;
  localparam int unsigned MAP_IDX_W  = $clog2(MAP_DEPTH);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SEQ_W;

  localparam logic [SEQ_BITS_W-1:0] SEQ_BITS_RST = SEQ_BITS_W'(3);
  localparam logic [WIN_W-1:0]      WIN_RST      = WIN_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQ_BITS = 2'd0,
    CFG_WIN_SIZE = 2'd1,
    CFG_INIT_SEQ = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_BUFFER  = 2'd1,
    KIND_DROP    = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIFF  = 4'b0010,
    ST_CLASS = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  // Control of the buffered-number bitmap.
  typedef struct packed {
    logic clear;
    logic shift;
    logic set;
  } map_ctrl_t;

  // Mask of valid sequence bits; width clamped to 1..SEQ_W.
  function automatic logic [SEQ_W-1:0] seq_mask_f(input logic [SEQ_BITS_W-1:0] bits);
    logic [SEQ_BITS_W-1:0] eff;
    logic [SEQ_W:0]        one_hot;
    eff = bits;
    if (eff == '0) begin
      eff = SEQ_BITS_W'(1);
    end else if (eff > SEQ_BITS_W'(SEQ_W)) begin
      eff = SEQ_BITS_W'(SEQ_W);
    end
    one_hot = (SEQ_W + 1)'(1) << eff;
    return SEQ_W'(one_hot - (SEQ_W + 1)'(1));
  endfunction

endpackage

`default_nettype wire

@@ hdl/srrw_map.sv @@
// ----------------------------------------------------------------------------
// srrw_map
// Bitmap of held out-of-order numbers; bit i stands for expected + i.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_receive_window_macros.svh"

module srrw_map import srrw_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire map_ctrl_t            ctrl_i,
  input  wire logic [MAP_IDX_W-1:0] idx_i,
  output logic                      bit_o,   // bit at idx_i
  output logic                      head_o,  // bit 0
  output logic                      next_o   // bit 1, head after a shift
);

  logic [MAP_DEPTH-1:0] map_q, map_d;

  always_comb begin
    map_d = map_q;
    if (ctrl_i.clear) begin
      map_d = '0;
    end else if (ctrl_i.shift) begin
      map_d = map_q >> 1;
    end else if (ctrl_i.set) begin
      map_d[idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else begin
      map_q <= map_d;
    end
  end

  assign bit_o  = map_q[idx_i];
  assign head_o = map_q[0];
  assign next_o = map_q[1];

  `SRRW_ASSERT_NXT(a_map_clear, clk_i, rst_ni, ctrl_i.clear, map_q == '0)
  `SRRW_ASSERT_IMP(a_map_set_nonzero, clk_i, rst_ni, ctrl_i.set && !ctrl_i.clear, idx_i != '0)
  `SRRW_ASSERT_NXT(a_map_shift_top, clk_i, rst_ni, ctrl_i.shift && !ctrl_i.clear,
                   !map_q[MAP_DEPTH-1])

endmodule

`default_nettype wire

@@ hdl/selective_repeat_receive_window.sv @@
// An item is accepted, its distance from expected is formed the next cycle, and its
// first result is loaded into the output register in ST_CLASS; held numbers drain in
// ST_DRAIN, all through one shared 16-bit adder. A new item is accepted only in ST_IDLE,
// and a full output register stalls the sequencer.
// Reset: expected = 0, bitmap clear, seq_bits = 3, win_size = 4; no clearing pass.
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Selective-repeat receiver: deliver in-order numbers, hold out-of-order ones
// inside the window, drop duplicates and numbers outside the window.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_receive_window_macros.svh"

module selective_repeat_receive_window import srrw_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [15:0]           s_axis_tdata,   // [15:0] seq_num
  // result items
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [31:0]                m_axis_tdata,   // [15:0] seq_out, [31:16] next_expected
  output logic [1:0]                 m_axis_tuser,   // [1:0] kind
  output logic                       m_axis_tlast    // last result of an item
);

  // --------------------------------------------------------------------------
  // Configuration and derived limits
  // --------------------------------------------------------------------------
  logic [SEQ_BITS_W-1:0] seq_bits_q;
  logic [WIN_W-1:0]      win_q;
  logic [SEQ_W-1:0]      seq_mask;
  logic [WIN_W-1:0]      win_eff;

  assign seq_mask = seq_mask_f(seq_bits_q);

  // Clamp the window to 1..min(mask, MAP_DEPTH).
  always_comb begin
    win_eff = (win_q == '0) ? WIN_W'(1) : win_q;
    if (SEQ_W'(win_eff) > seq_mask) begin
      win_eff = seq_mask[WIN_W-1:0];
    end
    if (win_eff > WIN_W'(MAP_DEPTH)) begin
      win_eff = WIN_W'(MAP_DEPTH);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [SEQ_W-1:0] exp_q, exp_d;
  logic [SEQ_W-1:0] s_q, s_d;     // masked arriving number
  logic [SEQ_W-1:0] dist_q, dist_d; // (s - expected) & mask

  logic             out_valid_q, out_valid_d;
  kind_e            out_kind_q, out_kind_d;
  logic [SEQ_W-1:0] out_seq_q, out_seq_d;
  logic [SEQ_W-1:0] out_next_q, out_next_d;
  logic             out_last_q, out_last_d;

  logic             in_acc;
  logic             slot_free;
  logic             load_out;

  // Shared adder: distance in ST_DIFF, expected + 1 otherwise.
  logic [SEQ_W-1:0] add_a, add_b, add_sum;

  // Bitmap interface
  map_ctrl_t             map_ctrl;
  logic                  map_bit, map_head, map_next;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;

  always_comb begin
    if (state_q == ST_DIFF) begin
      add_a = s_q;
      add_b = ~exp_q;
    end else begin
      add_a = exp_q;
      add_b = '0;
    end
    add_sum = (add_a + add_b + SEQ_W'(1)) & seq_mask;
  end

  srrw_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (map_ctrl),
    .idx_i  (dist_q[MAP_IDX_W-1:0]),
    .bit_o  (map_bit),
    .head_o (map_head),
    .next_o (map_next)
  );

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    s_d         = s_q;
    dist_d      = dist_q;
    map_ctrl    = '0;
    load_out    = 1'b0;
    out_kind_d  = out_kind_q;
    out_seq_d   = out_seq_q;
    out_next_d  = out_next_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        // Configuration must only arrive while idle; the block itself does not enforce it.
        if (cfg_we_i) begin
          unique case (cfg_idx_i)
            CFG_SEQ_BITS: begin
              exp_d        = exp_q & seq_mask_f(cfg_data_i[SEQ_BITS_W-1:0]);
              map_ctrl.clear = 1'b1;
            end
            CFG_WIN_SIZE: begin
              exp_d        = exp_q & seq_mask;
              map_ctrl.clear = 1'b1;
            end
            CFG_INIT_SEQ: begin
              exp_d        = cfg_data_i & seq_mask;
              map_ctrl.clear = 1'b1;
            end
            default: ;  // unmapped index: ignore
          endcase
        end
        if (in_acc) begin
          s_d     = s_axis_tdata & seq_mask;
          state_d = ST_DIFF;
        end
      end

      ST_DIFF: begin
        dist_d  = add_sum;
        state_d = ST_CLASS;
      end

      ST_CLASS: begin
        if (slot_free) begin
          load_out  = 1'b1;
          out_seq_d = s_q;
          if (dist_q == '0) begin
            // In order: deliver, advance, drain if the next one is held.
            exp_d          = add_sum;
            map_ctrl.shift = 1'b1;
            out_kind_d     = KIND_DELIVER;
            out_next_d     = add_sum;
            out_last_d     = !map_next;
            state_d        = map_next ? ST_DRAIN : ST_IDLE;
          end else begin
            out_next_d = exp_q;
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
            if (dist_q < SEQ_W'(win_eff) && !map_bit) begin
              map_ctrl.set = 1'b1;
              out_kind_d   = KIND_BUFFER;
            end else begin
              // duplicate or outside the window
              out_kind_d = KIND_DROP;
            end
          end
        end
      end

      ST_DRAIN: begin
        if (slot_free) begin
          load_out       = 1'b1;
          exp_d          = add_sum;
          map_ctrl.shift = 1'b1;
          out_kind_d     = KIND_DELIVER;
          out_seq_d      = exp_q;
          out_next_d     = add_sum;
          out_last_d     = !map_next;
          state_d        = map_next ? ST_DRAIN : ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exp_q       <= '0;
      seq_bits_q  <= SEQ_BITS_RST;
      win_q       <= WIN_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == CFG_SEQ_BITS) begin
        seq_bits_q <= cfg_data_i[SEQ_BITS_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_WIN_SIZE) begin
        win_q <= cfg_data_i[WIN_W-1:0];
      end
    end
  end

  // Payload holds, no reset needed.
  always_ff @(posedge clk_i) begin
    s_q        <= s_d;
    dist_q     <= dist_d;
    out_kind_q <= out_kind_d;
    out_seq_q  <= out_seq_d;
    out_next_q <= out_next_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_next_q, out_seq_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `SRRW_ASSERT_NXT(a_accept_to_diff, clk_i, rst_ni, in_acc, state_q == ST_DIFF)
  `SRRW_ASSERT_IMP(a_exp_in_range, clk_i, rst_ni, 1'b1, (exp_q & ~seq_mask) == '0)
  `SRRW_ASSERT_IMP(a_drain_has_head, clk_i, rst_ni, state_q == ST_DRAIN, map_head)

endmodule

`default_nettype wire
